>>> rtl/core/slc_pkg.sv
package slc_pkg;

    localparam int VAL_W     = 32;
    localparam int ENTRIES_W = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_FIND    = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_BEGIN   = 3'd4,
        OP_END     = 3'd5,
        OP_PRIOR   = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    // broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic                    rep;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/core/slc_if.sv
interface slc_cmd_if;
    import slc_pkg::*;

    logic                    valid;
    logic                    ready;
    t_op                     op;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface slc_res_if;
    import slc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic signed [VAL_W-1:0]     data;
    logic        [ENTRIES_W-1:0] entries;

    modport source (output valid, output ok, output data, output entries, input ready);
    modport sink   (input valid, input ok, input data, input entries, output ready);
endinterface

>>> rtl/core/sorted_list_with_cursor.sv
// Sorted list of up to DEPTH signed 32-bit values with a cursor. One command is
// accepted per clock unless a held result blocks it: every stored entry sits in
// its own cell, and all cells compare against the command value and shift toward
// or away from their neighbor in the same cycle. The result appears on o_res in
// the cycle after the command is accepted and is held until taken; i_cmd.ready
// stays high while the result register is empty or is being emptied. The
// combinational depth is set by the ripple of the compare chain through all DEPTH
// cells. There is no clearing pass after reset.
module sorted_list_with_cursor #(
    parameter int DEPTH = slc_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slc_cmd_if.sink   i_cmd,
    slc_res_if.source o_res
);
    import slc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] n_cur;
    logic          r_cur_valid;
    logic          n_cur_valid;

    logic                    r_out_valid;
    logic                    r_ok;
    logic                    n_ok;
    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;

    logic                    fire;
    logic                    full;
    t_cell_ctl               ctl;
    logic signed [VAL_W-1:0] cell_val [DEPTH];
    logic [DEPTH:0]          le_chain;
    logic [DEPTH:0]          seen_chain;
    logic [DEPTH-1:0]        ins_here;
    logic [DEPTH-1:0]        first;
    logic [PW-1:0]           ins_pos;
    logic [PW-1:0]           find_pos;
    logic [PW-1:0]           rd_idx;
    logic signed [VAL_W-1:0] rd_val;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign fire        = i_cmd.valid && i_cmd.ready;
    assign full        = r_count == CW'(DEPTH);

    assign ctl.ins   = fire && (i_cmd.op == OP_INSERT) && !full;
    assign ctl.rem   = fire && (i_cmd.op == OP_REMOVE) && r_cur_valid;
    assign ctl.rep   = fire && (i_cmd.op == OP_REPLACE) && r_cur_valid;
    assign ctl.value = i_cmd.value;

    assign le_chain[0]   = 1'b1;
    assign seen_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        slc_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_cursor     (r_cur),
            .i_left       ((g == 0) ? i_cmd.value : cell_val[(g == 0) ? 0 : g - 1]),
            .i_right      ((g == DEPTH - 1) ? cell_val[g]
                                            : cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .i_le_chain   (le_chain[g]),
            .i_seen_chain (seen_chain[g]),
            .o_val        (cell_val[g]),
            .o_le_chain   (le_chain[g+1]),
            .o_seen_chain (seen_chain[g+1]),
            .o_ins_here   (ins_here[g]),
            .o_first      (first[g])
        );
    end

    // one-hot to index for the insert slot and the first match
    always_comb begin
        ins_pos  = '0;
        find_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ins_here[i]) begin
                ins_pos = ins_pos | PW'(i);
            end
            if (first[i]) begin
                find_pos = find_pos | PW'(i);
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_ok        = 1'b0;
        case (i_cmd.op)
            OP_INSERT: begin
                if (!full) begin
                    n_count     = r_count + CW'(1);
                    n_cur       = ins_pos;
                    n_cur_valid = 1'b1;
                    n_ok        = 1'b1;
                end
            end
            OP_FIND: begin
                n_ok        = seen_chain[DEPTH];
                n_cur_valid = seen_chain[DEPTH];
                if (seen_chain[DEPTH]) begin
                    n_cur = find_pos;
                end
            end
            OP_REMOVE: begin
                if (r_cur_valid) begin
                    n_count     = r_count - CW'(1);
                    n_cur_valid = r_count != CW'(1);
                    n_ok        = 1'b1;
                    if (r_cur != '0) begin
                        n_cur = r_cur - PW'(1);
                    end
                end
            end
            OP_REPLACE: begin
                n_ok = r_cur_valid;
            end
            OP_BEGIN: begin
                n_cur       = '0;
                n_cur_valid = r_count != '0;
                n_ok        = r_count != '0;
            end
            OP_END: begin
                if (r_count != '0) begin
                    n_cur       = PW'(r_count - CW'(1));
                    n_cur_valid = 1'b1;
                    n_ok        = 1'b1;
                end
            end
            OP_PRIOR: begin
                if (r_cur_valid && (r_cur != '0)) begin
                    n_cur = r_cur - PW'(1);
                    n_ok  = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count     = '0;
                n_cur       = '0;
                n_cur_valid = 1'b0;
                n_ok        = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // read the pre-command array at the old cursor for remove, else at the new one
    assign rd_idx = (i_cmd.op == OP_REMOVE) ? r_cur : n_cur;

    always_comb begin
        rd_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) == rd_idx) begin
                rd_val = cell_val[i];
            end
        end
    end

    always_comb begin
        if (n_ok && ((i_cmd.op == OP_INSERT) || (i_cmd.op == OP_REPLACE))) begin
            n_data = i_cmd.value;
        end else if (n_ok && (i_cmd.op == OP_REMOVE)) begin
            n_data = rd_val;
        end else if (n_cur_valid) begin
            n_data = rd_val;
        end else begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_cur       <= n_cur;
                r_cur_valid <= n_cur_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each transaction
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ok   <= n_ok;
            r_data <= n_data;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.ok      = r_ok;
    assign o_res.data    = r_data;
    assign o_res.entries = ENTRIES_W'(r_count);

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (CW'(r_cur) < r_count))
        else $error("cursor points past the stored entries");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (i_cmd.op == OP_CLEAR)) |=> ((r_count == '0) && !r_cur_valid))
        else $error("clear left entries or a valid cursor");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (i_cmd.op == OP_INSERT) && !full)
            |=> (r_count == $past(r_count) + CW'(1)) && r_cur_valid)
        else $error("insert did not add an entry");

    a_result_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted transaction produced no result");

endmodule

>>> rtl/core/slc_cell.sv
module slc_cell #(
    parameter int DEPTH = slc_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                             i_clk,
    input  slc_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_count,
    input  logic [$clog2(DEPTH)-1:0]         i_cursor,
    input  logic signed [slc_pkg::VAL_W-1:0] i_left,
    input  logic signed [slc_pkg::VAL_W-1:0] i_right,
    input  logic                             i_le_chain,
    input  logic                             i_seen_chain,
    output logic signed [slc_pkg::VAL_W-1:0] o_val,
    output logic                             o_le_chain,
    output logic                             o_seen_chain,
    output logic                             o_ins_here,
    output logic                             o_first
);
    import slc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    occ;
    logic                    le;
    logic                    match;

    assign occ   = CW'(IDX) < i_count;
    assign le    = occ && (r_val <= i_ctl.value);
    assign match = occ && (r_val == i_ctl.value);

    // this cell and every cell before it hold a value <= the key
    assign o_le_chain   = i_le_chain && le;
    assign o_ins_here   = i_le_chain && !le;
    assign o_seen_chain = i_seen_chain || match;
    assign o_first      = match && !i_seen_chain;
    assign o_val        = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !o_le_chain) begin
            n_val = i_le_chain ? i_ctl.value : i_left;
        end else if (i_ctl.rem && (PW'(IDX) >= i_cursor)) begin
            n_val = i_right;
        end else if (i_ctl.rep && (PW'(IDX) == i_cursor)) begin
            n_val = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> verif/slc_list_checker.sv
module slc_list_checker #(
    parameter int DEPTH = slc_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slc_cmd_if        i_cmd,
    slc_res_if        i_res,
    output int        o_errors,
    output int        o_outstanding
);
    import slc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        ok;
        logic signed [VAL_W-1:0]     data;
        logic        [ENTRIES_W-1:0] entries;
    } t_list_result;

    // mirror of the list contents, ascending in 0..n_entries-1
    logic signed [VAL_W-1:0] sorted_vals [DEPTH];
    int unsigned             n_entries;
    int unsigned             cursor_idx;
    bit                      cursor_on;

    t_list_result pending_results [$];
    int           mismatch_cnt;

    assign o_errors = mismatch_cnt;

    function automatic t_list_result apply_list_op(t_op op, logic signed [VAL_W-1:0] v);
        t_list_result            r;
        int unsigned             p;
        bit                      took_out;
        logic signed [VAL_W-1:0] taken_val;
        r         = '0;
        took_out  = 1'b0;
        taken_val = '0;
        case (op)
            OP_INSERT: begin
                if (n_entries < DEPTH) begin
                    p = 0;
                    // new entry lands after all entries less than or equal to it
                    while (p < n_entries && sorted_vals[p] <= v)
                        p++;
                    for (int i = n_entries; i > p; i--)
                        sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[p] = v;
                    n_entries++;
                    cursor_idx = p;
                    cursor_on  = 1'b1;
                    r.ok       = 1'b1;
                end
            end
            OP_FIND: begin
                cursor_on = 1'b0;
                for (int i = 0; i < n_entries; i++) begin
                    if (sorted_vals[i] == v) begin
                        cursor_idx = i;
                        cursor_on  = 1'b1;
                        r.ok       = 1'b1;
                        break;
                    end
                end
            end
            OP_REMOVE: begin
                if (cursor_on && cursor_idx < n_entries) begin
                    taken_val = sorted_vals[cursor_idx];
                    for (int i = cursor_idx; i + 1 < n_entries; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    n_entries--;
                    if (cursor_idx > 0)
                        cursor_idx--;
                    cursor_on = (n_entries > 0);
                    took_out  = 1'b1;
                    r.ok      = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (cursor_on && cursor_idx < n_entries) begin
                    sorted_vals[cursor_idx] = v;
                    r.ok = 1'b1;
                end
            end
            OP_BEGIN: begin
                cursor_idx = 0;
                cursor_on  = (n_entries > 0);
                r.ok       = cursor_on;
            end
            OP_END: begin
                if (n_entries > 0) begin
                    cursor_idx = n_entries - 1;
                    cursor_on  = 1'b1;
                    r.ok       = 1'b1;
                end
            end
            OP_PRIOR: begin
                if (cursor_on && cursor_idx < n_entries && cursor_idx > 0) begin
                    cursor_idx--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                n_entries  = 0;
                cursor_idx = 0;
                cursor_on  = 1'b0;
                r.ok       = 1'b1;
            end
        endcase
        if (took_out)
            r.data = taken_val;
        else if (cursor_on && cursor_idx < n_entries)
            r.data = sorted_vals[cursor_idx];
        r.entries = ENTRIES_W'(n_entries);
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%08h got 0x%08h", $time, field, want, got);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            n_entries  = 0;
            cursor_idx = 0;
            cursor_on  = 1'b0;
            pending_results.delete();
            mismatch_cnt = 0;
        end else begin
            // results are checked first: a transaction accepted now cannot answer this edge
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none got ok=%0b data=0x%08h entries=%0d",
                             $time, i_res.ok, i_res.data, i_res.entries);
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.ok !== want.ok)
                        note_mismatch("ok", VAL_W'(want.ok), VAL_W'(i_res.ok));
                    if (i_res.data !== want.data)
                        note_mismatch("data", want.data, i_res.data);
                    if (i_res.entries !== want.entries)
                        note_mismatch("entries", VAL_W'(want.entries), VAL_W'(i_res.entries));
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                pending_results.push_back(apply_list_op(i_cmd.op, i_cmd.value));
        end
        o_outstanding <= pending_results.size();
    end

endmodule

>>> verif/tb.sv
module tb;
    import slc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1130;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 300000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   outstanding;
    bit   hold_off_req = 1'b0;
    int   cycle_cnt    = 0;

    logic [VAL_W-1:0] val_pool [8];

    slc_cmd_if cmd_if ();
    slc_res_if res_if ();

    sorted_list_with_cursor #(.DEPTH(DEPTH_DEF)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    slc_list_checker #(.DEPTH(DEPTH_DEF)) u_list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one transaction and return at the edge where it is taken
    task automatic send_cmd(t_op op, logic signed [VAL_W-1:0] v);
        cmd_if.valid <= 1'b1;
        cmd_if.op    <= op;
        cmd_if.value <= v;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
    endtask

    task automatic idle_cmd(int unsigned n);
        cmd_if.valid <= 1'b0;
        cmd_if.op    <= t_op'(3'($urandom_range(0, 7)));
        cmd_if.value <= $urandom();
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        idle_cmd(1);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    function automatic t_op pick_op(bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 55) return OP_INSERT;
            if (r < 65) return OP_FIND;
            if (r < 70) return OP_REMOVE;
            if (r < 75) return OP_REPLACE;
            if (r < 80) return OP_BEGIN;
            if (r < 86) return OP_END;
            if (r < 99) return OP_PRIOR;
        end else begin
            if (r < 15) return OP_INSERT;
            if (r < 30) return OP_FIND;
            if (r < 60) return OP_REMOVE;
            if (r < 68) return OP_REPLACE;
            if (r < 74) return OP_BEGIN;
            if (r < 80) return OP_END;
            if (r < 97) return OP_PRIOR;
        end
        return OP_CLEAR;
    endfunction

    // small values and a shared pool make duplicates and find hits common
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return VAL_W'($urandom_range(0, 16)) - VAL_W'(8);
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 80)
            return val_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    initial begin
        int unsigned mode;
        int unsigned tick;
        res_if.ready <= 1'b0;
        mode = 0;
        tick = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (tick % 50 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= $urandom_range(0, 1);
                    2:       res_if.ready <= (tick % 4 == 0);
                    default: res_if.ready <= ($urandom_range(0, 99) < 85);
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        bit          filling;
        int unsigned burst_left;
        cmd_if.valid <= 1'b0;
        cmd_if.op    <= OP_INSERT;
        cmd_if.value <= '0;
        i_rst_n      <= 1'b0;
        filling      = 1'b0;
        burst_left   = 0;
        foreach (val_pool[j])
            val_pool[j] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: everything but insert and clear fails
        send_cmd(OP_REMOVE, 32'sd0);
        send_cmd(OP_REPLACE, 32'sd5);
        send_cmd(OP_BEGIN, 32'sd0);
        send_cmd(OP_END, 32'sd0);
        send_cmd(OP_PRIOR, 32'sd0);
        send_cmd(OP_FIND, 32'sd0);
        send_cmd(OP_INSERT, 32'sd0);
        send_cmd(OP_INSERT, 32'h7fff_ffff);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_INSERT, -32'sd1);
        // duplicate goes after its equal, find lands on the first one
        send_cmd(OP_INSERT, 32'sd0);
        send_cmd(OP_FIND, 32'sd0);
        send_cmd(OP_PRIOR, 32'sd0);
        send_cmd(OP_PRIOR, 32'sd0);
        send_cmd(OP_PRIOR, 32'sd0);
        send_cmd(OP_END, 32'sd0);
        send_cmd(OP_REPLACE, 32'h8000_0000);
        send_cmd(OP_REMOVE, 32'sd0);
        send_cmd(OP_BEGIN, 32'sd0);
        // removing the head keeps the cursor on the new head
        send_cmd(OP_REMOVE, 32'sd0);
        send_cmd(OP_FIND, 32'sd12345);
        send_cmd(OP_REMOVE, 32'sd0);
        send_cmd(OP_CLEAR, 32'sd0);
        send_cmd(OP_END, 32'sd0);
        idle_cmd(3);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0) begin
                filling = !filling;
                foreach (val_pool[j])
                    val_pool[j] = $urandom();
            end
            if (k == 300)
                hold_off_req = 1'b1;
            if (k == 600)
                drain_results();
            send_cmd(pick_op(filling), pick_value());
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 10);
                idle_cmd($urandom_range(1, 6));
            end else begin
                burst_left--;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/slc_pkg.sv
rtl/core/slc_if.sv
rtl/core/slc_cell.sv
rtl/core/sorted_list_with_cursor.sv
verif/slc_list_checker.sv
verif/tb.sv
